// ----- design/steq_pkg.sv -----
// Shared types and constants for the sorted timer event queue.
package steq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned DELAY_W     = 16;
  localparam int unsigned TAG_W       = 8;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [0:0] OP_INSERT = 1'b0;
  localparam logic [0:0] OP_TICK   = 1'b1;

  localparam logic [KIND_W-1:0] MOVE_KIND = KIND_W'(5);

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EXPIRED  = 2'd2;
  localparam logic [1:0] ST_IDLE     = 2'd3;

  typedef struct packed {
    logic [0:0]         opcode;
    logic [KIND_W-1:0]  event_kind;
    logic [TAG_W-1:0]   event_tag;
    logic [DELAY_W-1:0] delay;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [KIND_W-1:0] out_kind;
    logic [TAG_W-1:0]  out_tag;
    logic              last;
  } out_req_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic               insert;
    logic               pop;
    logic               decr;
    logic [KIND_W-1:0]  kind;
    logic [TAG_W-1:0]   tag;
    logic [DELAY_W-1:0] delay;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic              full;
    logic              head_zero;
    logic              next_zero;
    logic [KIND_W-1:0] head_kind;
    logic [TAG_W-1:0]  head_tag;
  } dp_stat_t;

endpackage

// ----- design/steq_datapath.sv -----
// Slot array with parallel compare-and-shift insert, head pop and decrement.
module steq_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  steq_pkg::dp_cmd_t   cmd,
  output steq_pkg::dp_stat_t  stat
);

  localparam int unsigned D = steq_pkg::QUEUE_DEPTH;

  logic [steq_pkg::KIND_W-1:0]  kind_r   [D];
  logic [steq_pkg::TAG_W-1:0]   tag_r    [D];
  logic [steq_pkg::DELAY_W-1:0] rem_r    [D];
  logic [steq_pkg::KIND_W-1:0]  kind_nxt [D];
  logic [steq_pkg::TAG_W-1:0]   tag_nxt  [D];
  logic [steq_pkg::DELAY_W-1:0] rem_nxt  [D];
  logic [steq_pkg::OCC_W-1:0]   occ_r;
  logic [steq_pkg::OCC_W-1:0]   occ_nxt;
  logic [D-1:0]                 stay;
  logic [D-1:0]                 stay_prev;
  logic                         is_move;

  // An entry stays in place when it sorts ahead of the new event.
  always_comb begin
    is_move = (cmd.kind == steq_pkg::MOVE_KIND);
    for (int i = 0; i < D; i++) begin
      stay[i] = (steq_pkg::OCC_W'(i) < occ_r) &&
                (is_move ? (rem_r[i] <= cmd.delay) : (rem_r[i] < cmd.delay));
    end
    stay_prev = {stay[D-2:0], 1'b1};
  end

  always_comb begin
    kind_nxt = kind_r;
    tag_nxt  = tag_r;
    rem_nxt  = rem_r;
    occ_nxt  = occ_r;
    if (cmd.insert) begin
      occ_nxt = occ_r + 1'b1;
      for (int i = 0; i < D; i++) begin
        if (stay[i]) begin
          kind_nxt[i] = kind_r[i];
        end else if (stay_prev[i]) begin
          kind_nxt[i] = cmd.kind;
          tag_nxt[i]  = cmd.tag;
          rem_nxt[i]  = cmd.delay;
        end else if (i > 0) begin
          kind_nxt[i] = kind_r[i-1];
          tag_nxt[i]  = tag_r[i-1];
          rem_nxt[i]  = rem_r[i-1];
        end
      end
    end else if (cmd.pop) begin
      occ_nxt = occ_r - 1'b1;
      for (int i = 0; i < D - 1; i++) begin
        kind_nxt[i] = kind_r[i+1];
        tag_nxt[i]  = tag_r[i+1];
        rem_nxt[i]  = rem_r[i+1];
      end
    end else if (cmd.decr) begin
      for (int i = 0; i < D; i++) begin
        if (rem_r[i] != '0) begin
          rem_nxt[i] = rem_r[i] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    tag_r  <= tag_nxt;
    rem_r  <= rem_nxt;
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_comb begin
    stat.full      = (occ_r == steq_pkg::OCC_W'(D));
    stat.head_zero = (occ_r != '0) && (rem_r[0] == '0);
    stat.next_zero = (occ_r > steq_pkg::OCC_W'(1)) && (rem_r[1] == '0);
    stat.head_kind = kind_r[0];
    stat.head_tag  = tag_r[0];
  end

endmodule

// ----- design/steq_ctrl.sv -----
// Controller: request handshake, tick drain sequencing and result register.
module steq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  steq_pkg::in_req_t   in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output steq_pkg::out_req_t  out_req,
  output steq_pkg::dp_cmd_t   cmd,
  input  steq_pkg::dp_stat_t  stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAIN,
    S_DECR
  } state_t;

  state_t                      state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  steq_pkg::out_req_t          out_req_r, out_req_nxt;
  logic [steq_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        can_load;
  logic                        expire;
  logic                        last_exp;

  assign can_load = !out_valid_r || !out_stall;
  assign expire   = stat.head_zero && (cnt_r < steq_pkg::CNT_W'(steq_pkg::MAX_RESULTS));
  assign last_exp = !(stat.next_zero &&
                      ((cnt_r + 1'b1) < steq_pkg::CNT_W'(steq_pkg::MAX_RESULTS)));

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_req_nxt   = out_req_r;
    cnt_nxt       = cnt_r;
    cmd.insert    = 1'b0;
    cmd.pop       = 1'b0;
    cmd.decr      = 1'b0;
    cmd.kind      = in_req.event_kind;
    cmd.tag       = in_req.event_tag;
    cmd.delay     = in_req.delay;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && can_load) begin
          if (in_req.opcode == steq_pkg::OP_INSERT) begin
            cmd.insert           = !stat.full;
            out_valid_nxt        = 1'b1;
            out_req_nxt.status   = stat.full ? steq_pkg::ST_FULL : steq_pkg::ST_INSERTED;
            out_req_nxt.out_kind = '0;
            out_req_nxt.out_tag  = '0;
            out_req_nxt.last     = 1'b1;
          end else begin
            cnt_nxt   = '0;
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          if (expire) begin
            cmd.pop              = 1'b1;
            cnt_nxt              = cnt_r + 1'b1;
            out_req_nxt.status   = steq_pkg::ST_EXPIRED;
            out_req_nxt.out_kind = stat.head_kind;
            out_req_nxt.out_tag  = stat.head_tag;
            out_req_nxt.last     = last_exp;
            if (last_exp) begin
              state_nxt = S_DECR;
            end
          end else begin
            cmd.decr             = 1'b1;
            out_req_nxt.status   = steq_pkg::ST_IDLE;
            out_req_nxt.out_kind = '0;
            out_req_nxt.out_tag  = '0;
            out_req_nxt.last     = 1'b1;
            state_nxt            = S_IDLE;
          end
        end
      end
      S_DECR: begin
        cmd.decr  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_req_r <= out_req_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE) || !can_load;
  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

`ifndef NO_ASSERTIONS
  a_pop_needs_zero_head: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> stat.head_zero)
    else $error("pop issued without an expired head");

  a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> !stat.full)
    else $error("insert issued into a full queue");

  a_last_pop_then_decr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop && last_exp) |=> (state_r == S_DECR))
    else $error("final expiry not followed by decrement");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= steq_pkg::CNT_W'(steq_pkg::MAX_RESULTS))
    else $error("expiry count exceeds limit");

  a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.insert, cmd.pop, cmd.decr}))
    else $error("more than one datapath command at once");
`endif

endmodule

// ----- design/sorted_timer_event_queue.sv -----
// Top level of the sorted timer event queue: controller plus slot datapath.
// Insert: back-to-back inserts run at one per cycle while the output is not stalled.
// Tick: accept, then one pop per expired result, then a decrement; an idle tick decrements without popping.
// The drain loop pops one head entry per cycle, while the output is not stalled, through the shared slot shift array.
// Results sit in one output register; a request is taken only when it is empty or being read.
// Synchronous active-low reset empties the queue and drops any pending result.
module sorted_timer_event_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  steq_pkg::in_req_t   in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output steq_pkg::out_req_t  out_req
);

  // Command and status link between controller and datapath.
  steq_pkg::dp_cmd_t  cmd;
  steq_pkg::dp_stat_t stat;

  // Sequence requests and hold results.
  steq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Hold the sorted slots; insert, pop and decrement on command.
  steq_datapath u_datapath (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the sorted timer event queue: stimulus, shadow queue and scoreboard.
`timescale 1ns / 100ps

module tb_top;

  // Worst case per request: the input gap, the time in the block, and 16 results that each
  // wait out an output stall. With ~210 requests that worst case stays below CYCLE_LIMIT.
  localparam int unsigned CYCLE_LIMIT = 500_000;
  // Let the block settle this long at the end.
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned RANDOM_REQS = 180;
  localparam int unsigned REPORT_MAX = 10;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  steq_pkg::in_req_t  in_req;
  logic               out_valid;
  logic               out_stall;
  steq_pkg::out_req_t out_req;

  sorted_timer_event_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  // Requests waiting to be driven, and results the block still owes us.
  steq_pkg::in_req_t  req_backlog[$];
  steq_pkg::out_req_t due_results[$];

  // Shadow copy of the event queue; position 0 is the head.
  logic [steq_pkg::KIND_W-1:0]  shadow_kind [steq_pkg::QUEUE_DEPTH];
  logic [steq_pkg::TAG_W-1:0]   shadow_tag  [steq_pkg::QUEUE_DEPTH];
  logic [steq_pkg::DELAY_W-1:0] shadow_left [steq_pkg::QUEUE_DEPTH];
  int unsigned                  shadow_count;

  // Handshake flags sampled at the rising edge and consumed at the falling edge.
  bit in_fire;
  bit out_fire;

  int unsigned in_gap;
  int unsigned out_hold;
  bit          in_calm;
  bit          out_calm;

  int unsigned cycle_count;
  int unsigned total_reqs;
  int unsigned reqs_taken;
  int unsigned inserts_taken;
  int unsigned ticks_taken;
  int unsigned results_checked;
  int unsigned expiries_seen;
  int unsigned drops_seen;
  int unsigned idles_seen;
  int unsigned check_failures;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Draw a random wait; now and then flip into or out of a stretch with no waits.
  function automatic int unsigned pick_wait(inout bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  // Mostly short delays so events expire often; a few longer ones to stretch the sort.
  function automatic logic [steq_pkg::DELAY_W-1:0] draw_delay();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return steq_pkg::DELAY_W'($urandom_range(0, 6));
    if (roll < 97) return steq_pkg::DELAY_W'($urandom_range(7, 40));
    return steq_pkg::DELAY_W'($urandom_range(41, 127));
  endfunction

  function automatic logic [steq_pkg::KIND_W-1:0] draw_kind();
    if ($urandom_range(0, 3) == 0) return steq_pkg::MOVE_KIND;
    return steq_pkg::KIND_W'($urandom_range(0, 7));
  endfunction

  task automatic plan_insert(input logic [steq_pkg::KIND_W-1:0] kind,
                             input logic [steq_pkg::TAG_W-1:0] tag,
                             input logic [steq_pkg::DELAY_W-1:0] delay);
    steq_pkg::in_req_t r;
    r.opcode     = steq_pkg::OP_INSERT;
    r.event_kind = kind;
    r.event_tag  = tag;
    r.delay      = delay;
    req_backlog.push_back(r);
  endtask

  // Fill the unused fields of a tick with noise; the block must ignore them.
  task automatic plan_tick();
    steq_pkg::in_req_t r;
    r.opcode     = steq_pkg::OP_TICK;
    r.event_kind = steq_pkg::KIND_W'($urandom_range(0, 7));
    r.event_tag  = steq_pkg::TAG_W'($urandom_range(0, 255));
    r.delay      = steq_pkg::DELAY_W'($urandom);
    req_backlog.push_back(r);
  endtask

  // Apply one accepted request to the shadow queue and queue up the results it owes.
  task automatic step_shadow_queue(input steq_pkg::in_req_t r);
    steq_pkg::out_req_t res;
    int unsigned pos;
    int unsigned i;
    int unsigned n;
    res = '0;
    if (r.opcode == steq_pkg::OP_INSERT) begin
      res.last = 1'b1;
      if (shadow_count >= steq_pkg::QUEUE_DEPTH) begin
        // Queue full: drop the event, state stays as it is.
        res.status = steq_pkg::ST_FULL;
      end else begin
        // A move goes behind equal remaining times, anything else in front of them.
        pos = 0;
        if (r.event_kind == steq_pkg::MOVE_KIND) begin
          while (pos < shadow_count && shadow_left[pos] <= r.delay) pos++;
        end else begin
          while (pos < shadow_count && shadow_left[pos] < r.delay) pos++;
        end
        for (i = shadow_count; i > pos; i--) begin
          shadow_kind[i] = shadow_kind[i-1];
          shadow_tag[i]  = shadow_tag[i-1];
          shadow_left[i] = shadow_left[i-1];
        end
        shadow_kind[pos] = r.event_kind;
        shadow_tag[pos]  = r.event_tag;
        shadow_left[pos] = r.delay;
        shadow_count++;
        res.status = steq_pkg::ST_INSERTED;
      end
      due_results.push_back(res);
    end else begin
      // Pop every zero entry at the head, up to the per-tick result cap.
      n = 0;
      while (n < steq_pkg::MAX_RESULTS && shadow_count > 0 && shadow_left[0] == '0) begin
        res          = '0;
        res.status   = steq_pkg::ST_EXPIRED;
        res.out_kind = shadow_kind[0];
        res.out_tag  = shadow_tag[0];
        due_results.push_back(res);
        n++;
        for (i = 1; i < shadow_count; i++) begin
          shadow_kind[i-1] = shadow_kind[i];
          shadow_tag[i-1]  = shadow_tag[i];
          shadow_left[i-1] = shadow_left[i];
        end
        shadow_count--;
      end
      // Count down what is left; zero entries held back by the cap stay at zero.
      for (i = 0; i < shadow_count; i++) begin
        if (shadow_left[i] != '0) shadow_left[i] = shadow_left[i] - 1'b1;
      end
      if (n == 0) begin
        res        = '0;
        res.status = steq_pkg::ST_IDLE;
        res.last   = 1'b1;
        due_results.push_back(res);
      end else begin
        res      = due_results.pop_back();
        res.last = 1'b1;
        due_results.push_back(res);
      end
    end
  endtask

  // Request driver: present the next request at the falling edge, hold it while stalled,
  // and wait the drawn gap after each accepted request.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_req   <= '0;
      in_gap = 0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (req_backlog.size() != 0) begin
        in_req   <= req_backlog.pop_front();
        in_valid <= 1'b1;
        in_gap = pick_wait(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: after each accepted result, stall for a freshly drawn number of cycles.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = pick_wait(out_calm);
    end else begin
      if (out_fire) out_hold = pick_wait(out_calm);
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: sample both handshakes at the rising edge, advance the shadow queue on each
  // accepted request and check each accepted result against the oldest one owed.
  always @(posedge clk) begin : monitor
    steq_pkg::out_req_t want;
    cycle_count++;
    in_fire  = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    if (in_fire) begin
      step_shadow_queue(in_req);
      reqs_taken++;
      if (in_req.opcode == steq_pkg::OP_INSERT) inserts_taken++;
      else ticks_taken++;
    end
    if (out_fire) begin
      results_checked++;
      if (due_results.size() == 0) begin
        check_failures++;
        if (check_failures <= REPORT_MAX)
          $display("[%0d] unexpected result: status %0d kind %0d tag %02h last %0d",
                   cycle_count, out_req.status, out_req.out_kind, out_req.out_tag,
                   out_req.last);
      end else begin
        want = due_results.pop_front();
        case (want.status)
          steq_pkg::ST_EXPIRED: expiries_seen++;
          steq_pkg::ST_FULL:    drops_seen++;
          steq_pkg::ST_IDLE:    idles_seen++;
          default:              ;
        endcase
        if (out_req.status !== want.status || out_req.out_kind !== want.out_kind ||
            out_req.out_tag !== want.out_tag || out_req.last !== want.last) begin
          check_failures++;
          if (check_failures <= REPORT_MAX)
            $display({"[%0d] result %0d: expected status %0d kind %0d tag %02h last %0d,",
                      " got status %0d kind %0d tag %02h last %0d"},
                     cycle_count, results_checked, want.status, want.out_kind,
                     want.out_tag, want.last, out_req.status, out_req.out_kind,
                     out_req.out_tag, out_req.last);
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles: %0d of %0d requests taken, %0d results owed",
               cycle_count, reqs_taken, total_reqs, due_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned i;
    int unsigned n;
    int unsigned episode;
    rst_n = 1'b0;

    // Directed: a tick on the empty queue idles.
    plan_tick();
    // Fill the queue with zero delays in a mix of kinds, including two moves, and tags
    // from 00 to ff; one more insert is dropped, and one tick drains all sixteen.
    for (i = 0; i < steq_pkg::QUEUE_DEPTH; i++)
      plan_insert(steq_pkg::KIND_W'(i), steq_pkg::TAG_W'(i * 17), '0);
    plan_insert(steq_pkg::KIND_W'(3), 8'ha5, '0);
    plan_tick();
    // Equal delays: kinds six and seven go in front of earlier equals, a move goes behind;
    // a new zero-delay move becomes the head.
    plan_insert(steq_pkg::KIND_W'(6), 8'h01, steq_pkg::DELAY_W'(1));
    plan_insert(steq_pkg::MOVE_KIND, 8'h02, steq_pkg::DELAY_W'(1));
    plan_insert(steq_pkg::KIND_W'(7), 8'h03, steq_pkg::DELAY_W'(1));
    plan_insert(steq_pkg::KIND_W'(0), 8'h04, steq_pkg::DELAY_W'(2));
    plan_insert(steq_pkg::MOVE_KIND, 8'h05, '0);
    plan_tick();
    plan_tick();
    plan_tick();

    // Random part: mostly insert bursts followed by ticks, some queue-filling bursts,
    // and single random requests as noise.
    n = req_backlog.size();
    while (req_backlog.size() < n + RANDOM_REQS) begin
      episode = $urandom_range(0, 9);
      if (episode <= 5) begin
        repeat ($urandom_range(1, 6))
          plan_insert(draw_kind(), steq_pkg::TAG_W'($urandom_range(0, 255)), draw_delay());
        repeat ($urandom_range(1, 6)) plan_tick();
      end else if (episode == 6) begin
        repeat ($urandom_range(10, 18))
          plan_insert(draw_kind(), steq_pkg::TAG_W'($urandom_range(0, 255)),
                      steq_pkg::DELAY_W'($urandom_range(0, 3)));
        repeat ($urandom_range(1, 5)) plan_tick();
      end else if ($urandom_range(0, 1) == 0) begin
        plan_insert(steq_pkg::KIND_W'($urandom_range(0, 7)),
                    steq_pkg::TAG_W'($urandom_range(0, 255)), draw_delay());
      end else begin
        plan_tick();
      end
    end

    // Last of all the largest delay, so it never blocks a slot for the rest of the run.
    plan_insert(steq_pkg::KIND_W'(7), 8'hff, {steq_pkg::DELAY_W{1'b1}});
    plan_tick();
    total_reqs = req_backlog.size();

    // Hold reset, then release it at a falling edge.
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every request to go in and every owed result to come out, then let the
    // block settle to catch any stray result.
    while (reqs_taken < total_reqs || due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run drove %0d requests (%0d inserts, %0d ticks) and checked %0d results",
             reqs_taken, inserts_taken, ticks_taken, results_checked);
    $display("Results covered %0d expired events, %0d full-queue drops, %0d idle ticks",
             expiries_seen, drops_seen, idles_seen);
    if (check_failures == 0 && due_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d result mismatches", check_failures);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
